// ----- rtl/bmhq_pkg.sv -----
// bmhq_pkg: shared types and codes for the binary max-heap queue.
// Payload structs, status/command codes, controller state and the
// command/status structs between controller and datapath. No dependencies.
package bmhq_pkg;

    localparam int HEAP_SLOTS_DEF = 128;
    localparam int KEY_W          = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_FIELD_W  = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key_in;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [KEY_W-1:0]  removed_key;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHECK,
        ST_UP_CMP,
        ST_RM_LAST,
        ST_RM_HOLD,
        ST_DN_CHECK,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    // register update applied by the datapath
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS_START,
        OP_FLAG_FULL,
        OP_FLAG_EMPTY,
        OP_RM_START,
        OP_TAKE_ROOT,
        OP_TAKE_LAST,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT,
        OP_POS_PARENT,
        OP_POS_PICK
    } op_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_ROOT,
        RD_PARENT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_HOLD,
        WR_RDDATA,
        WR_CHILD
    } wr_sel_t;

    typedef struct packed {
        op_t     op;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic pos_is_root;
        logic up_greater;
        logic left_out;
        logic right_in;
        logic child_greater;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/bmhq_datapath.sv -----
// bmhq_datapath: heap memory, count, position and key registers, result register.
// Driven by ctrl_cmd_t from bmhq_ctrl; reports dp_status_t. Uses bmhq_pkg.
module bmhq_datapath #(
    parameter int HEAP_SLOTS = bmhq_pkg::HEAP_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bmhq_pkg::in_t          s_data,
    input  bmhq_pkg::ctrl_cmd_t    cmd,
    output bmhq_pkg::dp_status_t   st,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bmhq_pkg::out_t         m_data
);

    localparam int AW = $clog2(HEAP_SLOTS);
    localparam int EW = (AW > bmhq_pkg::COUNT_FIELD_W) ? AW : bmhq_pkg::COUNT_FIELD_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(HEAP_SLOTS - 1);
    localparam logic [AW-1:0] ROOT_SLOT = AW'(1);

    logic [bmhq_pkg::KEY_W-1:0] mem [HEAP_SLOTS];

    logic [AW-1:0]                count_reg, count_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [AW-1:0]                pick_reg, pick_next;
    logic [bmhq_pkg::KEY_W-1:0]   hold_reg, hold_next;
    logic [bmhq_pkg::KEY_W-1:0]   child_reg, child_next;
    logic [bmhq_pkg::KEY_W-1:0]   removed_reg, removed_next;
    logic [bmhq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [bmhq_pkg::KEY_W-1:0]   rd_data_reg;
    logic                         out_valid_reg, out_valid_next;
    bmhq_pkg::out_t               out_data_reg, out_data_next;

    logic [AW:0]                  left_idx, right_idx;
    logic [AW-1:0]                parent_idx;
    logic [AW-1:0]                rd_addr, wr_addr;
    logic                         rd_en, wr_en;
    logic [bmhq_pkg::KEY_W-1:0]   wr_data;
    logic [EW-1:0]                count_ext;
    logic                         right_bigger;

    assign left_idx   = {pos_reg, 1'b0};
    assign right_idx  = {pos_reg, 1'b1};
    assign parent_idx = pos_reg >> 1;
    assign count_ext  = EW'(count_reg);

    assign right_bigger = $signed(rd_data_reg) > $signed(child_reg);

    assign st.is_remove     = (s_data.command == bmhq_pkg::CMD_REMOVE);
    assign st.full          = (count_reg == LAST_SLOT);
    assign st.empty         = (count_reg == '0);
    assign st.pos_is_root   = (pos_reg == ROOT_SLOT);
    assign st.up_greater    = $signed(hold_reg) > $signed(rd_data_reg);
    assign st.left_out      = left_idx > {1'b0, count_reg};
    assign st.right_in      = right_idx <= {1'b0, count_reg};
    assign st.child_greater = $signed(child_reg) > $signed(hold_reg);
    assign st.out_free      = !out_valid_reg || m_ready;

    // memory ports
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = ROOT_SLOT;
        unique case (cmd.rd_sel)
            bmhq_pkg::RD_NONE:   rd_en   = 1'b0;
            bmhq_pkg::RD_ROOT:   rd_addr = ROOT_SLOT;
            bmhq_pkg::RD_PARENT: rd_addr = parent_idx;
            bmhq_pkg::RD_LAST:   rd_addr = count_reg;
            bmhq_pkg::RD_LEFT:   rd_addr = left_idx[AW-1:0];
            bmhq_pkg::RD_RIGHT:  rd_addr = right_idx[AW-1:0];
            default:             rd_en   = 1'b0;
        endcase
    end

    assign wr_addr = pos_reg;

    always_comb begin
        wr_en   = 1'b1;
        wr_data = hold_reg;
        unique case (cmd.wr_sel)
            bmhq_pkg::WR_NONE:   wr_en   = 1'b0;
            bmhq_pkg::WR_HOLD:   wr_data = hold_reg;
            bmhq_pkg::WR_RDDATA: wr_data = rd_data_reg;
            bmhq_pkg::WR_CHILD:  wr_data = child_reg;
            default:             wr_en   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // register updates
    always_comb begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        pick_next    = pick_reg;
        hold_next    = hold_reg;
        child_next   = child_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        unique case (cmd.op)
            bmhq_pkg::OP_NONE: begin
            end
            bmhq_pkg::OP_INS_START: begin
                hold_next    = s_data.key_in;
                count_next   = count_reg + AW'(1);
                pos_next     = count_reg + AW'(1);
                status_next  = bmhq_pkg::STATUS_DONE;
                removed_next = '0;
            end
            bmhq_pkg::OP_FLAG_FULL: begin
                status_next  = bmhq_pkg::STATUS_FULL;
                removed_next = '0;
            end
            bmhq_pkg::OP_FLAG_EMPTY: begin
                status_next  = bmhq_pkg::STATUS_EMPTY;
                removed_next = '0;
            end
            bmhq_pkg::OP_RM_START: begin
                status_next  = bmhq_pkg::STATUS_DONE;
            end
            bmhq_pkg::OP_TAKE_ROOT: begin
                removed_next = rd_data_reg;
            end
            bmhq_pkg::OP_TAKE_LAST: begin
                hold_next  = rd_data_reg;
                count_next = count_reg - AW'(1);
                pos_next   = ROOT_SLOT;
            end
            bmhq_pkg::OP_TAKE_LEFT: begin
                child_next = rd_data_reg;
                pick_next  = left_idx[AW-1:0];
            end
            bmhq_pkg::OP_TAKE_RIGHT: begin
                if (right_bigger) begin
                    child_next = rd_data_reg;
                    pick_next  = right_idx[AW-1:0];
                end
            end
            bmhq_pkg::OP_POS_PARENT: begin
                pos_next = parent_idx;
            end
            bmhq_pkg::OP_POS_PICK: begin
                pos_next = pick_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        pos_reg     <= pos_next;
        pick_reg    <= pick_next;
        hold_reg    <= hold_next;
        child_reg   <= child_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next            = 1'b1;
            out_data_next.status      = status_reg;
            out_data_next.removed_key = removed_reg;
            out_data_next.entry_count = count_ext[bmhq_pkg::COUNT_FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_SLOT)
        else $error("heap count beyond capacity");

    a_no_slot0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_addr != '0))
        else $error("write to unused slot 0");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == bmhq_pkg::OP_FLAG_FULL) |=> $stable(count_reg))
        else $error("dropped insert changed count");

    a_remove_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == bmhq_pkg::OP_TAKE_LAST) |=> (count_reg == $past(count_reg) - AW'(1)))
        else $error("remove did not decrement count");

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// bmhq_ctrl: sequencer for insert/sift-up and remove/sift-down.
// Issues ctrl_cmd_t to bmhq_datapath, reads dp_status_t. Uses bmhq_pkg.
module bmhq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmhq_pkg::dp_status_t st,
    output bmhq_pkg::ctrl_cmd_t  cmd
);

    bmhq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmhq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.op       = bmhq_pkg::OP_NONE;
        cmd.rd_sel   = bmhq_pkg::RD_NONE;
        cmd.wr_sel   = bmhq_pkg::WR_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            bmhq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!st.is_remove) begin
                        if (st.full) begin
                            cmd.op     = bmhq_pkg::OP_FLAG_FULL;
                            state_next = bmhq_pkg::ST_DONE;
                        end else begin
                            cmd.op     = bmhq_pkg::OP_INS_START;
                            state_next = bmhq_pkg::ST_UP_CHECK;
                        end
                    end else if (st.empty) begin
                        cmd.op     = bmhq_pkg::OP_FLAG_EMPTY;
                        state_next = bmhq_pkg::ST_DONE;
                    end else begin
                        cmd.op     = bmhq_pkg::OP_RM_START;
                        cmd.rd_sel = bmhq_pkg::RD_ROOT;
                        state_next = bmhq_pkg::ST_RM_LAST;
                    end
                end
            end
            bmhq_pkg::ST_UP_CHECK: begin
                if (st.pos_is_root) begin
                    cmd.wr_sel = bmhq_pkg::WR_HOLD;
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    cmd.rd_sel = bmhq_pkg::RD_PARENT;
                    state_next = bmhq_pkg::ST_UP_CMP;
                end
            end
            bmhq_pkg::ST_UP_CMP: begin
                if (st.up_greater) begin
                    // parent moves down into the hole
                    cmd.wr_sel = bmhq_pkg::WR_RDDATA;
                    cmd.op     = bmhq_pkg::OP_POS_PARENT;
                    state_next = bmhq_pkg::ST_UP_CHECK;
                end else begin
                    cmd.wr_sel = bmhq_pkg::WR_HOLD;
                    state_next = bmhq_pkg::ST_DONE;
                end
            end
            bmhq_pkg::ST_RM_LAST: begin
                cmd.op     = bmhq_pkg::OP_TAKE_ROOT;
                cmd.rd_sel = bmhq_pkg::RD_LAST;
                state_next = bmhq_pkg::ST_RM_HOLD;
            end
            bmhq_pkg::ST_RM_HOLD: begin
                cmd.op     = bmhq_pkg::OP_TAKE_LAST;
                state_next = bmhq_pkg::ST_DN_CHECK;
            end
            bmhq_pkg::ST_DN_CHECK: begin
                if (st.left_out) begin
                    cmd.wr_sel = bmhq_pkg::WR_HOLD;
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    cmd.rd_sel = bmhq_pkg::RD_LEFT;
                    state_next = bmhq_pkg::ST_DN_LEFT;
                end
            end
            bmhq_pkg::ST_DN_LEFT: begin
                cmd.op = bmhq_pkg::OP_TAKE_LEFT;
                if (st.right_in) begin
                    cmd.rd_sel = bmhq_pkg::RD_RIGHT;
                    state_next = bmhq_pkg::ST_DN_RIGHT;
                end else begin
                    state_next = bmhq_pkg::ST_DN_CMP;
                end
            end
            bmhq_pkg::ST_DN_RIGHT: begin
                cmd.op     = bmhq_pkg::OP_TAKE_RIGHT;
                state_next = bmhq_pkg::ST_DN_CMP;
            end
            bmhq_pkg::ST_DN_CMP: begin
                if (st.child_greater) begin
                    // larger child moves up into the hole
                    cmd.wr_sel = bmhq_pkg::WR_CHILD;
                    cmd.op     = bmhq_pkg::OP_POS_PICK;
                    state_next = bmhq_pkg::ST_DN_CHECK;
                end else begin
                    cmd.wr_sel = bmhq_pkg::WR_HOLD;
                    state_next = bmhq_pkg::ST_DONE;
                end
            end
            bmhq_pkg::ST_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = bmhq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/binary_max_heap_queue_core.sv -----
// binary_max_heap_queue_core: top level of the max-heap priority queue.
// Instantiates bmhq_ctrl and bmhq_datapath; types from bmhq_pkg.
//
// Usage:
//   s_* channel: one transfer per command. command = insert pushes key_in,
//   command = remove pops the maximum key. Keys are signed 32-bit.
//   m_* channel: exactly one result per command: status (done, full, empty),
//   removed_key (0 unless a remove succeeded) and entry_count after the item.
//   Capacity is HEAP_SLOTS-1 keys; slot 0 of the heap memory is unused.
// Steps after the accepting edge (result register free):
//   full insert or empty remove: goes straight to the result register.
//   insert: per level the key climbs, a parent read, then a
//   compare-and-write; a key that reaches the root is written without a read.
//   remove: root read and last-slot read, then per level a left read, a
//   right read and pick when a right child exists, and a compare-and-write;
//   a key that lands in a slot with no child is written without child reads.
// Sequencing: one command at a time; the next transfer can be taken in the
//   cycle after the result is loaded.
// Reset: aresetn (synchronous, active low) empties the heap at once; memory
//   contents are not cleared, only slots 1 up to the count are ever read.
// Stall: the result sits in an output register until m_ready; the next
//   command is taken meanwhile, and its result waits for the register.
module binary_max_heap_queue_core #(
    parameter int HEAP_SLOTS = bmhq_pkg::HEAP_SLOTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bmhq_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bmhq_pkg::out_t m_data
);

    bmhq_pkg::ctrl_cmd_t  cmd;
    bmhq_pkg::dp_status_t st;

    // sequencer: accepts a transfer only when idle, steps the sift loop
    bmhq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // heap memory, working registers and the result register
    bmhq_datapath #(
        .HEAP_SLOTS (HEAP_SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
